// ===== rtl/core/pfa_pkg.sv =====
package pfa_pkg;

  localparam int unsigned BINS_DEF    = 32;
  localparam int unsigned OVERLAP_DEF = 4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FOLD,
    ST_FOLD_DRAIN,
    ST_DFT,
    ST_DFT_DRAIN,
    ST_EMIT
  } pfa_state_e;

  // One queued word, already classified by the front end.
  typedef struct packed {
    logic        is_tap;
    logic        tap_ok;
    logic [6:0]  tap_idx;
    logic [15:0] tap_val;
    logic [15:0] re;
    logic [15:0] im;
  } pfa_cmd_t;

  // Back end status seen by the front end.
  typedef struct packed {
    logic take;
    logic clearing;
  } pfa_ctl_t;

endpackage

// ===== rtl/core/pfa_front.sv =====
module pfa_front #(
  parameter int unsigned N = pfa_pkg::BINS_DEF * pfa_pkg::OVERLAP_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic [6:0]        tap_index_i,
  input  logic [15:0]       tap_value_i,
  input  logic [15:0]       sample_real_i,
  input  logic [15:0]       sample_imag_i,
  output logic              cmd_valid_o,
  output pfa_pkg::pfa_cmd_t cmd_o,
  input  pfa_pkg::pfa_ctl_t ctl_i
);

  localparam int unsigned AW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned CW = (AW + 1 > 8) ? AW + 1 : 8;

  pfa_pkg::pfa_cmd_t q_mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       accept;
  pfa_pkg::pfa_cmd_t cmd_in;

  assign in_stall_o = (cnt_q == 2'd2) || ctl_i.clearing;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_in.is_tap  = !req_type_i;
    cmd_in.tap_ok  = CW'(tap_index_i) < CW'(N);
    cmd_in.tap_idx = tap_index_i;
    cmd_in.tap_val = tap_value_i;
    cmd_in.re      = sample_real_i;
    cmd_in.im      = sample_imag_i;
  end

  always_comb begin
    wr_ptr_d = accept ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = ctl_i.take ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + (accept ? 2'd1 : 2'd0) - (ctl_i.take ? 2'd1 : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];

endmodule

// ===== rtl/core/pfa_back.sv =====
module pfa_back #(
  parameter int unsigned BINS    = pfa_pkg::BINS_DEF,
  parameter int unsigned OVERLAP = pfa_pkg::OVERLAP_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  pfa_pkg::pfa_cmd_t   cmd_i,
  output pfa_pkg::pfa_ctl_t   ctl_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  bin_real_o,
  output logic signed [31:0]  bin_imag_o,
  output logic [4:0]          bin_index_o,
  output logic                last_bin_o
);

  localparam int unsigned N     = OVERLAP * BINS;
  localparam int unsigned HALF  = BINS / 2;
  localparam int unsigned AW    = $clog2(N);
  localparam int unsigned BW    = $clog2(BINS);
  localparam int unsigned OW    = (OVERLAP > 1) ? $clog2(OVERLAP) : 1;
  localparam int unsigned PW    = $clog2(HALF);
  localparam int unsigned FB_W  = 32 + $clog2(OVERLAP);
  localparam int unsigned PRW   = FB_W + 16;
  localparam int unsigned ACC_W = PRW + 1 + BW;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Series term divisors (2k-1)(2k) for cosine and (2k)(2k+1) for sine, k = 1..6.
  localparam logic [5:0][7:0] COS_DIV = {8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [5:0][7:0] SIN_DIV = {8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

  // cos and sin of 2*pi*m/BINS in Q1.15, packed as {cos, sin}.
  function automatic logic [31:0] tw_entry(input int m);
    longint unsigned x, x2, tc, ts, sc, ss, cq, sq, rr;
    int q, r, c, s, t;
    q = (4 * m) / BINS;
    r = (4 * m) % BINS;
    if (2 * r > BINS) begin
      x = (HALF_PI_Q30 * longint'(BINS - r)) / BINS;
    end else begin
      x = (HALF_PI_Q30 * longint'(r)) / BINS;
    end
    x2 = (x * x) >> 30;
    tc = 64'd1073741824;
    ts = x;
    sc = tc;
    ss = x;
    for (int k = 1; k <= 6; k++) begin
      tc = ((tc * x2) >> 30) / 64'(COS_DIV[k - 1]);
      ts = ((ts * x2) >> 30) / 64'(SIN_DIV[k - 1]);
      if (k % 2 == 1) begin
        sc = sc - tc;
        ss = ss - ts;
      end else begin
        sc = sc + tc;
        ss = ss + ts;
      end
    end
    if (2 * r > BINS) begin
      cq = ss;
      sq = sc;
    end else begin
      cq = sc;
      sq = ss;
    end
    rr = (cq + 64'd16384) >> 15;
    c  = (rr > 64'd32767) ? 32767 : int'(rr);
    rr = (sq + 64'd16384) >> 15;
    s  = (rr > 64'd32767) ? 32767 : int'(rr);
    for (int j = 0; j < 4; j++) begin
      if (j < q) begin
        t = c;
        c = -s;
        s = t;
      end
    end
    return {c[15:0], s[15:0]};
  endfunction

  logic [31:0] tw_tab [BINS];
  for (genvar g = 0; g < BINS; g++) begin : g_tw
    localparam logic [31:0] TwVal = tw_entry(g);
    assign tw_tab[g] = TwVal;
  end

  pfa_pkg::pfa_state_e state_q, state_d;

  logic [AW-1:0] clr_q, wp_q;
  logic [PW-1:0] ph_q;
  logic [BW-1:0] fi_q, k_q, n_q, m_q;
  logic [OW-1:0] fo_q;

  logic take, clearing, fold_issue, dft_issue, emit_load, out_free;
  logic is_sample, frame_start, pipe_empty;

  // Pipeline stage registers.
  logic          v1_q, v2_q;
  logic          fold1_q, fold2_q, first1_q, first2_q, last1_q, last2_q;
  logic [BW-1:0] i1_q, i2_q;
  logic signed [15:0]     sr1_q, si1_q, cf1_q, c1_q, s1_q;
  logic signed [FB_W-1:0] fbr1_q, fbi1_q;
  logic signed [PRW-1:0]  pa_q, pb_q, pc_q, pd_q;
  logic signed [FB_W-1:0] facc_q, fsum;
  logic signed [ACC_W-1:0] dr_q, di_q, dr_sum, di_sum, finr_q, fini_q;

  logic signed [15:0]     sre_mem [N];
  logic signed [15:0]     sim_mem [N];
  logic signed [15:0]     coef_mem [N];
  logic signed [FB_W-1:0] fbr_mem [BINS];
  logic signed [FB_W-1:0] fbi_mem [BINS];

  logic [AW-1:0] p_addr, rd_addr, tap_addr;
  logic [AW:0]   sum_addr;
  logic [BW:0]   m_sum;

  logic        out_valid_q;
  logic signed [31:0] out_re_q, out_im_q;
  logic [BW-1:0] out_k_q;
  logic signed [31:0] rnd_re, rnd_im;

  function automatic logic signed [31:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] v, q;
    v = a + (ACC_W'(1) <<< 29);
    q = v >>> 30;
    if (q > ACC_W'(64'sd2147483647)) begin
      return 32'sh7fffffff;
    end else if (q < -ACC_W'(64'sd2147483648)) begin
      return 32'sh80000000;
    end else begin
      return q[31:0];
    end
  endfunction

  assign out_free    = !out_valid_q || !out_stall_i;
  assign is_sample   = cmd_valid_i && !cmd_i.is_tap;
  assign frame_start = is_sample && (ph_q == PW'(HALF - 1));
  assign pipe_empty  = !v1_q && !v2_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pfa_pkg::ST_CLEAR: begin
        if (clr_q == AW'(N - 1)) state_d = pfa_pkg::ST_IDLE;
      end
      pfa_pkg::ST_IDLE: begin
        if (frame_start) state_d = pfa_pkg::ST_FOLD;
      end
      pfa_pkg::ST_FOLD: begin
        if (fi_q == BW'(BINS - 1) && fo_q == OW'(OVERLAP - 1)) begin
          state_d = pfa_pkg::ST_FOLD_DRAIN;
        end
      end
      pfa_pkg::ST_FOLD_DRAIN: begin
        if (pipe_empty) state_d = pfa_pkg::ST_DFT;
      end
      pfa_pkg::ST_DFT: begin
        if (n_q == BW'(BINS - 1)) state_d = pfa_pkg::ST_DFT_DRAIN;
      end
      pfa_pkg::ST_DFT_DRAIN: begin
        if (pipe_empty) state_d = pfa_pkg::ST_EMIT;
      end
      pfa_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = (k_q == BW'(BINS - 1)) ? pfa_pkg::ST_IDLE : pfa_pkg::ST_DFT;
        end
      end
      default: state_d = pfa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    take       = 1'b0;
    clearing   = 1'b0;
    fold_issue = 1'b0;
    dft_issue  = 1'b0;
    emit_load  = 1'b0;
    case (state_q)
      pfa_pkg::ST_CLEAR: clearing   = 1'b1;
      pfa_pkg::ST_IDLE:  take       = cmd_valid_i;
      pfa_pkg::ST_FOLD:  fold_issue = 1'b1;
      pfa_pkg::ST_DFT:   dft_issue  = 1'b1;
      pfa_pkg::ST_EMIT:  emit_load  = out_free;
      default: ;
    endcase
  end

  assign ctl_o.take     = take;
  assign ctl_o.clearing = clearing;

  // Window element p lives at wp + p, wrapped, since wp points at the oldest sample.
  assign p_addr   = AW'(AW'(fo_q) * AW'(BINS) + AW'(fi_q));
  assign sum_addr = {1'b0, wp_q} + {1'b0, p_addr};
  assign rd_addr  = (sum_addr >= (AW + 1)'(N)) ? AW'(sum_addr - (AW + 1)'(N))
                                               : sum_addr[AW-1:0];
  assign tap_addr = AW'(N - 1) - AW'(cmd_i.tap_idx);
  assign m_sum    = {1'b0, m_q} + {1'b0, k_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfa_pkg::ST_CLEAR;
      clr_q   <= '0;
      wp_q    <= '0;
      ph_q    <= '0;
      fi_q    <= '0;
      fo_q    <= '0;
      k_q     <= '0;
      n_q     <= '0;
      m_q     <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clearing) clr_q <= clr_q + AW'(1);
      if (take && !cmd_i.is_tap) begin
        wp_q <= (wp_q == AW'(N - 1)) ? '0 : wp_q + AW'(1);
        ph_q <= (ph_q == PW'(HALF - 1)) ? '0 : ph_q + PW'(1);
      end
      if (fold_issue) begin
        if (fo_q == OW'(OVERLAP - 1)) begin
          fo_q <= '0;
          fi_q <= (fi_q == BW'(BINS - 1)) ? '0 : fi_q + BW'(1);
        end else begin
          fo_q <= fo_q + OW'(1);
        end
      end
      if (dft_issue) begin
        if (n_q == BW'(BINS - 1)) begin
          n_q <= '0;
          m_q <= '0;
        end else begin
          n_q <= n_q + BW'(1);
          m_q <= (m_sum >= (BW + 1)'(BINS)) ? BW'(m_sum - (BW + 1)'(BINS)) : m_sum[BW-1:0];
        end
      end
      if (emit_load) k_q <= (k_q == BW'(BINS - 1)) ? '0 : k_q + BW'(1);
      v1_q <= fold_issue || dft_issue;
      v2_q <= v1_q;
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sample and coefficient stores.
  always_ff @(posedge clk_i) begin
    if (clearing) begin
      sre_mem[clr_q]  <= '0;
      sim_mem[clr_q]  <= '0;
      coef_mem[clr_q] <= '0;
    end else if (take) begin
      if (cmd_i.is_tap) begin
        if (cmd_i.tap_ok) coef_mem[tap_addr] <= cmd_i.tap_val;
      end else begin
        sre_mem[wp_q] <= cmd_i.re;
        sim_mem[wp_q] <= cmd_i.im;
      end
    end
    sr1_q <= sre_mem[rd_addr];
    si1_q <= sim_mem[rd_addr];
    cf1_q <= coef_mem[p_addr];
  end

  // Stage 1 tags, frame buffer read and twiddle lookup.
  always_ff @(posedge clk_i) begin
    fold1_q  <= fold_issue;
    first1_q <= fold_issue ? (fo_q == '0) : (n_q == '0);
    last1_q  <= fold_issue ? (fo_q == OW'(OVERLAP - 1)) : (n_q == BW'(BINS - 1));
    i1_q     <= fi_q;
    fbr1_q   <= fbr_mem[n_q];
    fbi1_q   <= fbi_mem[n_q];
    c1_q     <= tw_tab[m_q][31:16];
    s1_q     <= tw_tab[m_q][15:0];
  end

  // Stage 2: products.
  always_ff @(posedge clk_i) begin
    fold2_q  <= fold1_q;
    first2_q <= first1_q;
    last2_q  <= last1_q;
    i2_q     <= i1_q;
    if (fold1_q) begin
      pa_q <= PRW'(sr1_q) * PRW'(cf1_q);
      pb_q <= PRW'(si1_q) * PRW'(cf1_q);
      pc_q <= '0;
      pd_q <= '0;
    end else begin
      pa_q <= PRW'(fbr1_q) * PRW'(c1_q);
      pb_q <= PRW'(fbi1_q) * PRW'(s1_q);
      pc_q <= PRW'(fbr1_q) * PRW'(s1_q);
      pd_q <= PRW'(fbi1_q) * PRW'(c1_q);
    end
  end

  // Stage 3: accumulate. The fold needs one accumulator per part, so the
  // imaginary fold has its own accumulator facci and sum fsumi beside facc and fsum.
  logic signed [FB_W-1:0] facci_q, fsumi;

  assign fsum   = (first2_q ? '0 : facc_q) + FB_W'(pa_q);
  assign fsumi  = (first2_q ? '0 : facci_q) + FB_W'(pb_q);
  assign dr_sum = (first2_q ? '0 : dr_q) + (ACC_W'(pa_q) - ACC_W'(pb_q));
  assign di_sum = (first2_q ? '0 : di_q) + (ACC_W'(pc_q) + ACC_W'(pd_q));

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      if (fold2_q) begin
        facc_q  <= fsum;
        facci_q <= fsumi;
        if (last2_q) begin
          fbr_mem[BW'(BINS - 1) - i2_q] <= fsum;
          fbi_mem[BW'(BINS - 1) - i2_q] <= fsumi;
        end
      end else begin
        dr_q <= dr_sum;
        di_q <= di_sum;
        if (last2_q) begin
          finr_q <= dr_sum;
          fini_q <= di_sum;
        end
      end
    end
  end

  assign rnd_re = round_sat(finr_q);
  assign rnd_im = round_sat(fini_q);

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_re_q <= rnd_re;
      out_im_q <= rnd_im;
      out_k_q  <= k_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_real_o  = out_re_q;
  assign bin_imag_o  = out_im_q;
  assign bin_index_o = 5'(out_k_q);
  assign last_bin_o  = (out_k_q == BW'(BINS - 1));

endmodule

// ===== rtl/core/polyphase_filterbank_analysis_unit.sv =====
// Channel | Direction | Handshake            | Word
// in      | input     | in_valid_i/in_stall_o   | req_type, tap_index, tap_value, sample
// out     | output    | out_valid_o/out_stall_i | bin_real, bin_imag, bin_index, last_bin
//
// A tap load or a sample that does not complete a frame is taken by the back end while idle.
// Every BINS/2-th sample starts a frame: weighting of the N window samples through one read port
// of the sample store, then per bin a pass over the BINS folded values on the complex
// multiply-accumulate unit and an output state.
// After reset a clearing pass over all N entries zeroes the sample and coefficient stores; the
// input is stalled meanwhile. A two-word queue lets the input run ahead of the back end.
// A stalled output word holds the back end in its output state until it is taken.
module polyphase_filterbank_analysis_unit #(
  parameter int unsigned BINS    = pfa_pkg::BINS_DEF,
  parameter int unsigned OVERLAP = pfa_pkg::OVERLAP_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [6:0]         tap_index_i,
  input  logic signed [15:0] tap_value_i,
  input  logic signed [15:0] sample_real_i,
  input  logic signed [15:0] sample_imag_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] bin_real_o,
  output logic signed [31:0] bin_imag_o,
  output logic [4:0]         bin_index_o,
  output logic               last_bin_o
);

  logic              cmd_valid;
  pfa_pkg::pfa_cmd_t cmd;
  pfa_pkg::pfa_ctl_t ctl;

  pfa_front #(
    .N(OVERLAP * BINS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .tap_index_i  (tap_index_i),
    .tap_value_i  (tap_value_i),
    .sample_real_i(sample_real_i),
    .sample_imag_i(sample_imag_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .ctl_i        (ctl)
  );

  pfa_back #(
    .BINS   (BINS),
    .OVERLAP(OVERLAP)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .ctl_o      (ctl),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .bin_real_o (bin_real_o),
    .bin_imag_o (bin_imag_o),
    .bin_index_o(bin_index_o),
    .last_bin_o (last_bin_o)
  );

endmodule

// ===== rtl/core/pfa_checker.sv =====
module pfa_checker #(
  parameter int unsigned BINS = pfa_pkg::BINS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] bin_real_o,
  input logic [4:0]  bin_index_o,
  input logic        last_bin_o
);

  // Valid, real part and bin index hold while the word is stalled.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bin_real_o)
      && $stable(bin_index_o))
    else $error("stalled output word changed");

  // The last bin carries the highest index.
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_bin_o |-> bin_index_o == 5'(BINS - 1))
    else $error("last bin flag on wrong index");

  // Within a frame, bins leave in increasing order.
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_bin_o |=>
      !out_valid_o || bin_index_o == $past(bin_index_o) + 5'd1)
    else $error("bin index did not advance by one");

  // A frame starts at bin zero.
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_bin_o |=> !out_valid_o || bin_index_o == 5'd0)
    else $error("new frame did not start at bin zero");

endmodule

bind polyphase_filterbank_analysis_unit pfa_checker #(.BINS(BINS)) u_pfa_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .bin_real_o (bin_real_o),
  .bin_index_o(bin_index_o),
  .last_bin_o (last_bin_o)
);
